// ===== src/ps2s1_pkg.sv =====
// Shared types, scancode constants and key-map tables for the PS/2 set-1 decoder.
// No dependencies; used by ps2s1_decode and ps2_set1_scancode_to_ascii.
package ps2s1_pkg;

	localparam int ScanW  = 8;
	localparam int CodeW  = 7;
	localparam int AsciiW = 7;
	localparam int LedW   = 3;
	localparam int DataW  = 16;

	localparam logic [ScanW-1:0] PREFIX_BYTE = 8'hE0;
	localparam logic [CodeW-1:0] KEY_LSHIFT  = 7'h2A;
	localparam logic [CodeW-1:0] KEY_RSHIFT  = 7'h36;
	localparam logic [CodeW-1:0] KEY_CTRL    = 7'h1D;
	localparam logic [CodeW-1:0] KEY_ALT     = 7'h38;
	localparam logic [CodeW-1:0] KEY_CAPS    = 7'h3A;
	localparam logic [CodeW-1:0] CAPS_LO     = 7'h10;
	localparam logic [CodeW-1:0] CAPS_HI     = 7'h32;
	localparam int               LED_CAPS_BIT = 2;

	typedef struct packed {
		logic shift;
		logic ctrl;
		logic alt;
		logic caps;
	} mod_state_t;

	typedef struct packed {
		logic              char_valid;
		logic [AsciiW-1:0] ascii_char;
		logic              led_update;
		logic [LedW-1:0]   led_bits;
		mod_state_t        mods;
	} dec_result_t;

	// US layout, unshifted.
	function automatic logic [AsciiW-1:0] map_plain(input logic [CodeW-1:0] idx);
		logic [AsciiW-1:0] c;
		unique case (idx)
			7'd2:  c = 7'h31;  7'd3:  c = 7'h32;  7'd4:  c = 7'h33;  7'd5:  c = 7'h34;
			7'd6:  c = 7'h35;  7'd7:  c = 7'h36;  7'd8:  c = 7'h37;  7'd9:  c = 7'h38;
			7'd10: c = 7'h39;  7'd11: c = 7'h30;  7'd12: c = 7'h2D;  7'd13: c = 7'h3D;
			7'd14: c = 7'h08;  7'd15: c = 7'h09;
			7'd16: c = 7'h71;  7'd17: c = 7'h77;  7'd18: c = 7'h65;  7'd19: c = 7'h72;
			7'd20: c = 7'h74;  7'd21: c = 7'h79;  7'd22: c = 7'h75;  7'd23: c = 7'h69;
			7'd24: c = 7'h6F;  7'd25: c = 7'h70;  7'd26: c = 7'h5B;  7'd27: c = 7'h5D;
			7'd28: c = 7'h0A;
			7'd30: c = 7'h61;  7'd31: c = 7'h73;  7'd32: c = 7'h64;  7'd33: c = 7'h66;
			7'd34: c = 7'h67;  7'd35: c = 7'h68;  7'd36: c = 7'h6A;  7'd37: c = 7'h6B;
			7'd38: c = 7'h6C;  7'd39: c = 7'h3B;  7'd40: c = 7'h27;  7'd41: c = 7'h60;
			7'd43: c = 7'h5C;
			7'd44: c = 7'h7A;  7'd45: c = 7'h78;  7'd46: c = 7'h63;  7'd47: c = 7'h76;
			7'd48: c = 7'h62;  7'd49: c = 7'h6E;  7'd50: c = 7'h6D;  7'd51: c = 7'h2C;
			7'd52: c = 7'h2E;  7'd53: c = 7'h2F;  7'd55: c = 7'h2A;  7'd57: c = 7'h20;
			default: c = '0;
		endcase
		return c;
	endfunction

	// US layout, shifted.
	function automatic logic [AsciiW-1:0] map_shift(input logic [CodeW-1:0] idx);
		logic [AsciiW-1:0] c;
		unique case (idx)
			7'd2:  c = 7'h21;  7'd3:  c = 7'h40;  7'd4:  c = 7'h23;  7'd5:  c = 7'h24;
			7'd6:  c = 7'h25;  7'd7:  c = 7'h5E;  7'd8:  c = 7'h26;  7'd9:  c = 7'h2A;
			7'd10: c = 7'h28;  7'd11: c = 7'h29;  7'd12: c = 7'h5F;  7'd13: c = 7'h2B;
			7'd14: c = 7'h08;  7'd15: c = 7'h09;
			7'd16: c = 7'h51;  7'd17: c = 7'h57;  7'd18: c = 7'h45;  7'd19: c = 7'h52;
			7'd20: c = 7'h54;  7'd21: c = 7'h59;  7'd22: c = 7'h55;  7'd23: c = 7'h49;
			7'd24: c = 7'h4F;  7'd25: c = 7'h50;  7'd26: c = 7'h7B;  7'd27: c = 7'h7D;
			7'd28: c = 7'h0A;
			7'd30: c = 7'h41;  7'd31: c = 7'h53;  7'd32: c = 7'h44;  7'd33: c = 7'h46;
			7'd34: c = 7'h47;  7'd35: c = 7'h48;  7'd36: c = 7'h4A;  7'd37: c = 7'h4B;
			7'd38: c = 7'h4C;  7'd39: c = 7'h3A;  7'd40: c = 7'h22;  7'd41: c = 7'h7E;
			7'd43: c = 7'h7C;
			7'd44: c = 7'h5A;  7'd45: c = 7'h58;  7'd46: c = 7'h43;  7'd47: c = 7'h56;
			7'd48: c = 7'h42;  7'd49: c = 7'h4E;  7'd50: c = 7'h4D;  7'd51: c = 7'h3C;
			7'd52: c = 7'h3E;  7'd53: c = 7'h3F;  7'd55: c = 7'h2A;  7'd57: c = 7'h20;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

// ===== src/ps2s1_decode.sv =====
// Combinational decode of one set-1 scancode against the current modifier state.
// Depends on ps2s1_pkg for the key constants, the key-map tables and the result struct.
module ps2s1_decode (
	input  logic [ps2s1_pkg::ScanW-1:0] scan_byte,
	input  ps2s1_pkg::mod_state_t       mods_cur,
	output ps2s1_pkg::mod_state_t       mods_next,
	output ps2s1_pkg::dec_result_t      result
);
	import ps2s1_pkg::*;

	logic [CodeW-1:0]  code;
	logic              release_key;
	logic              is_shift_key;
	logic [AsciiW-1:0] plain_c;
	logic [AsciiW-1:0] shift_c;
	logic              use_shift;
	logic [AsciiW-1:0] ch;
	logic              led;

	assign code         = scan_byte[CodeW-1:0];
	assign release_key  = scan_byte[ScanW-1];
	assign is_shift_key = (code == KEY_LSHIFT) || (code == KEY_RSHIFT);
	assign plain_c      = map_plain(code);
	assign shift_c      = map_shift(code);

	// Caps lock flips the shift choice only for letter keys.
	always_comb begin
		use_shift = mods_cur.shift;
		if (mods_cur.caps && code >= CAPS_LO && code <= CAPS_HI
				&& plain_c >= 7'h61 && plain_c <= 7'h7A) begin
			use_shift = ~mods_cur.shift;
		end
	end

	always_comb begin
		mods_next = mods_cur;
		ch        = '0;
		led       = 1'b0;
		priority if (scan_byte == PREFIX_BYTE) begin
			mods_next = mods_cur;
		end else if (release_key) begin
			// Releases of other keys leave the modifiers as they are.
			if (is_shift_key) begin
				mods_next.shift = 1'b0;
			end else if (code == KEY_CTRL) begin
				mods_next.ctrl = 1'b0;
			end else if (code == KEY_ALT) begin
				mods_next.alt = 1'b0;
			end
		end else if (is_shift_key) begin
			mods_next.shift = 1'b1;
		end else if (code == KEY_CTRL) begin
			mods_next.ctrl = 1'b1;
		end else if (code == KEY_ALT) begin
			mods_next.alt = 1'b1;
		end else if (code == KEY_CAPS) begin
			mods_next.caps = ~mods_cur.caps;
			led            = 1'b1;
		end else begin
			ch = use_shift ? shift_c : plain_c;
		end
	end

	always_comb begin
		result                         = '0;
		result.char_valid              = (ch != '0);
		result.ascii_char              = ch;
		result.led_update              = led;
		result.led_bits[LED_CAPS_BIT]  = mods_next.caps;
		result.mods                    = mods_next;
	end

endmodule

// ===== src/ps2_set1_scancode_to_ascii.sv =====
// Top level of the PS/2 set-1 scancode to ASCII decoder: stream ports, stage registers.
// Depends on ps2s1_pkg and ps2s1_decode.

// One scancode byte per transfer in, one result per transfer out. A byte is held in the
// input stage until it advances, is decoded there against the modifier flags, and the
// result is registered in the output stage; a new byte is taken every cycle while the output
// side keeps up. The modifier flags advance when a byte leaves the input stage, so each
// byte sees the effect of every byte before it. Results carry the character (tuser set
// when one was produced), the caps lock LED image and the current modifier state.
module ps2_set1_scancode_to_ascii (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [ps2s1_pkg::ScanW-1:0]  s_tdata,  // [7:0] scan_byte
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [ps2s1_pkg::DataW-1:0]  m_tdata,  // [6:0] ascii_char, [7] led_update,
	                                               // [10:8] led_bits, [11] shift_held,
	                                               // [12] ctrl_held, [13] alt_held,
	                                               // [14] caps_on, [15] zero
	output logic                         m_tuser   // [0] char_valid
);
	import ps2s1_pkg::*;

	logic              valid_s1;
	logic [ScanW-1:0]  byte_s1;
	logic              valid_s2;
	dec_result_t       res_s2;
	mod_state_t        mods_q;
	mod_state_t        mods_next;
	dec_result_t       res_comb;
	logic              advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	ps2s1_decode u_decode (
		.scan_byte (byte_s1),
		.mods_cur  (mods_q),
		.mods_next (mods_next),
		.result    (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			mods_q   <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				mods_q   <= mods_next;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.char_valid;
	assign m_tdata  = {1'b0, res_s2.mods.caps, res_s2.mods.alt, res_s2.mods.ctrl,
		res_s2.mods.shift, res_s2.led_bits, res_s2.led_update, res_s2.ascii_char};

endmodule

// ===== verif/ps2_set1_decode_checker.sv =====
`timescale 1ns / 100ps
// Checker for ps2_set1_scancode_to_ascii. It watches both stream channels, predicts
// each decoder result from the accepted scancode bytes, and compares the results field by field.
// Depends on ps2s1_pkg for widths, key codes and the result layout.
module ps2_set1_decode_checker
	import ps2s1_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [ScanW-1:0]  s_tdata,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [DataW-1:0]  m_tdata,
	input  logic              m_tuser,
	output int                mismatches,
	output int                outstanding,
	output int                results_checked,
	output int                chars_seen,
	output int                led_updates
);

	localparam int RELEASE_BIT = 7;

	byte unsigned key_plain [128];
	byte unsigned key_shift [128];

	logic shift_q, ctrl_q, alt_q, caps_q, prefix_q;
	dec_result_t expected_results [$];
	dec_result_t oldest;

	// US layout. An underscore in the plain row and a dash in the shifted row mark
	// codes that give no character.
	initial begin
		string plain_row;
		string shift_row;
		plain_row = "__1234567890-=__qwertyuiop[]__asdfghjkl;'`_\\zxcvbnm,./_*_ ";
		shift_row = "--!@#$%^&*()_+--QWERTYUIOP{}--ASDFGHJKL:\"~-|ZXCVBNM<>?-*- ";
		for (int i = 0; i < 128; i++) begin
			key_plain[i] = 0;
			key_shift[i] = 0;
		end
		for (int i = 0; i < plain_row.len(); i++) begin
			if (plain_row[i] != "_")
				key_plain[i] = plain_row[i];
			if (shift_row[i] != "-")
				key_shift[i] = shift_row[i];
		end
		// Backspace, tab and enter are the same in both layers.
		key_plain[14] = 8'h08;
		key_shift[14] = 8'h08;
		key_plain[15] = 8'h09;
		key_shift[15] = 8'h09;
		key_plain[28] = 8'h0A;
		key_shift[28] = 8'h0A;
	end

	// Advances the modifier state by one scancode byte and returns the result it yields.
	function automatic dec_result_t decode_scancode(input logic [ScanW-1:0] scan);
		dec_result_t       res;
		logic [CodeW-1:0]  code;
		logic [AsciiW-1:0] ch;
		logic              shifted;
		res = '0;
		ch = '0;
		code = scan[CodeW-1:0];
		if (scan == PREFIX_BYTE) begin
			prefix_q = 1'b1;
		end else begin
			prefix_q = 1'b0;
			if (scan[RELEASE_BIT]) begin
				if (code == KEY_LSHIFT || code == KEY_RSHIFT)
					shift_q = 1'b0;
				else if (code == KEY_CTRL)
					ctrl_q = 1'b0;
				else if (code == KEY_ALT)
					alt_q = 1'b0;
			end else if (code == KEY_LSHIFT || code == KEY_RSHIFT) begin
				shift_q = 1'b1;
			end else if (code == KEY_CTRL) begin
				ctrl_q = 1'b1;
			end else if (code == KEY_ALT) begin
				alt_q = 1'b1;
			end else if (code == KEY_CAPS) begin
				caps_q = !caps_q;
				res.led_update = 1'b1;
			end else begin
				shifted = shift_q;
				// Caps lock flips the layer for letters only.
				if (caps_q && code >= CAPS_LO && code <= CAPS_HI &&
				    key_plain[code] >= "a" && key_plain[code] <= "z")
					shifted = !shifted;
				ch = shifted ? key_shift[code][AsciiW-1:0] : key_plain[code][AsciiW-1:0];
			end
		end
		res.char_valid = (ch != '0);
		res.ascii_char = ch;
		res.led_bits[LED_CAPS_BIT] = caps_q;
		res.mods.shift = shift_q;
		res.mods.ctrl  = ctrl_q;
		res.mods.alt   = alt_q;
		res.mods.caps  = caps_q;
		return res;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q = 1'b0;
			ctrl_q = 1'b0;
			alt_q = 1'b0;
			caps_q = 1'b0;
			prefix_q = 1'b0;
			expected_results.delete();
			outstanding = 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(decode_scancode(s_tdata));
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing expected: tdata 0x%0h, tuser %b",
					       m_tdata, m_tuser);
					mismatches++;
				end else begin
					oldest = expected_results.pop_front();
					check_field("char_valid", 8'(oldest.char_valid), 8'(m_tuser));
					check_field("ascii_char", 8'(oldest.ascii_char), 8'(m_tdata[6:0]));
					check_field("led_update", 8'(oldest.led_update), 8'(m_tdata[7]));
					check_field("led_bits", 8'(oldest.led_bits), 8'(m_tdata[10:8]));
					check_field("shift_held", 8'(oldest.mods.shift), 8'(m_tdata[11]));
					check_field("ctrl_held", 8'(oldest.mods.ctrl), 8'(m_tdata[12]));
					check_field("alt_held", 8'(oldest.mods.alt), 8'(m_tdata[13]));
					check_field("caps_on", 8'(oldest.mods.caps), 8'(m_tdata[14]));
					check_field("tdata padding", 8'h00, 8'(m_tdata[15]));
					results_checked++;
					chars_seen += oldest.char_valid;
					led_updates += oldest.led_update;
				end
			end
			outstanding = expected_results.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Top of the testbench for ps2_set1_scancode_to_ascii: clock, reset, scancode stimulus,
// output back-pressure and the verdict. Depends on ps2s1_pkg, the decoder and its checker.
module testbench;
	import ps2s1_pkg::*;

	localparam int RandomItems = 750;
	localparam int CycleLimit  = 200000;

	localparam logic [CodeW-1:0] KEY_ESC     = 7'h01;
	localparam logic [CodeW-1:0] KEY_1       = 7'h02;
	localparam logic [CodeW-1:0] KEY_Q       = 7'h10;
	localparam logic [CodeW-1:0] KEY_BRACKET = 7'h1A;
	localparam logic [CodeW-1:0] KEY_BSLASH  = 7'h2B;
	localparam logic [CodeW-1:0] KEY_SPACE   = 7'h39;
	localparam logic [CodeW-1:0] KEY_F1      = 7'h3B;
	localparam logic [CodeW-1:0] KEY_LAST    = 7'h7F;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [ScanW-1:0] s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [DataW-1:0] m_tdata;
	logic             m_tuser;

	// While set, neither side inserts idle cycles.
	bit calm = 1'b0;
	int scans_sent = 0;
	int cycle_count = 0;
	int mismatches, outstanding, results_checked, chars_seen, led_updates;

	ps2_set1_scancode_to_ascii u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	ps2_set1_decode_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.chars_seen      (chars_seen),
		.led_updates     (led_updates)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Entered and left at a falling edge; returns once the byte has been transferred.
	task automatic send_scan(input logic [ScanW-1:0] scan);
		int gap;
		gap = calm ? 0 : $urandom_range(7, 0);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= scan;
		do @(posedge clk); while (!s_tready);
		scans_sent++;
		@(negedge clk);
	endtask

	task automatic tap_key(input logic [CodeW-1:0] code, input bit extended);
		if (extended)
			send_scan(PREFIX_BYTE);
		send_scan({1'b0, code});
		if (extended)
			send_scan(PREFIX_BYTE);
		send_scan({1'b1, code});
	endtask

	// Mostly keys of the main block, now and then any code at all.
	function automatic logic [CodeW-1:0] pick_key();
		if ($urandom_range(7, 0) == 0)
			return CodeW'($urandom_range(127, 0));
		return CodeW'($urandom_range(57, 1));
	endfunction

	function automatic logic [CodeW-1:0] pick_modifier();
		case ($urandom_range(3, 0))
			0:       return KEY_LSHIFT;
			1:       return KEY_RSHIFT;
			2:       return KEY_CTRL;
			default: return KEY_ALT;
		endcase
	endfunction

	// Output side back-pressure.
	initial begin
		int stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(7, 0);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	initial begin
		int               kind;
		int               first_random;
		logic [CodeW-1:0] held;
		bit               extended;
		bit               release_it;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: byte extremes, prefixed modifiers, shift, caps lock and dead keys.
		send_scan(8'h00);
		send_scan(8'hFF);
		send_scan(PREFIX_BYTE);
		send_scan({1'b0, KEY_CTRL});
		send_scan(PREFIX_BYTE);
		send_scan({1'b1, KEY_CTRL});
		send_scan(PREFIX_BYTE);
		send_scan({1'b0, KEY_ALT});
		send_scan({1'b1, KEY_ALT});
		send_scan({1'b0, KEY_LSHIFT});
		send_scan({1'b0, KEY_Q});
		send_scan({1'b0, KEY_1});
		send_scan({1'b1, KEY_LSHIFT});
		send_scan({1'b0, KEY_RSHIFT});
		send_scan({1'b1, KEY_RSHIFT});
		send_scan({1'b0, KEY_CAPS});
		send_scan({1'b1, KEY_CAPS});
		send_scan({1'b0, CAPS_HI});
		send_scan({1'b0, KEY_BRACKET});
		send_scan({1'b0, KEY_BSLASH});
		send_scan({1'b0, KEY_LSHIFT});
		send_scan({1'b0, KEY_Q});
		send_scan({1'b1, KEY_LSHIFT});
		send_scan({1'b0, KEY_CAPS});
		send_scan({1'b0, KEY_F1});
		send_scan({1'b1, KEY_Q});
		send_scan({1'b0, KEY_LAST});
		send_scan(8'h80);
		send_scan({1'b0, KEY_ESC});
		send_scan({1'b0, KEY_SPACE});

		// Random part: mostly typing with modifiers, some broken sequences and noise.
		first_random = scans_sent;
		while (scans_sent - first_random < RandomItems) begin
			if ($urandom_range(39, 0) == 0)
				calm = !calm;
			kind = $urandom_range(99, 0);
			if (kind < 45) begin
				tap_key(pick_key(), $urandom_range(9, 0) == 0);
			end else if (kind < 60) begin
				held = ($urandom_range(1, 0) == 0) ? KEY_LSHIFT : KEY_RSHIFT;
				send_scan({1'b0, held});
				repeat ($urandom_range(4, 1)) tap_key(pick_key(), 1'b0);
				send_scan({1'b1, held});
			end else if (kind < 70) begin
				held = ($urandom_range(1, 0) == 0) ? KEY_CTRL : KEY_ALT;
				extended = 1'($urandom_range(1, 0));
				if (extended)
					send_scan(PREFIX_BYTE);
				send_scan({1'b0, held});
				tap_key(pick_key(), 1'b0);
				if (extended)
					send_scan(PREFIX_BYTE);
				send_scan({1'b1, held});
			end else if (kind < 76) begin
				tap_key(KEY_CAPS, 1'b0);
			end else if (kind < 82) begin
				// A press or a release without its partner.
				release_it = 1'($urandom_range(1, 0));
				send_scan({release_it, pick_modifier()});
			end else begin
				send_scan(ScanW'($urandom_range(255, 0)));
			end
		end
		s_tvalid <= 1'b0;

		wait (outstanding == 0);
		repeat (10) @(posedge clk);
		$display("Sent %0d scancode bytes; checked %0d results, %0d with a character,",
		         scans_sent, results_checked, chars_seen);
		$display("%0d with a caps lock LED update. Stimulus mixed shifted and caps lock typing,",
		         led_updates);
		$display("prefixed modifiers and raw noise bytes.");
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles with %0d results outstanding.",
		         cycle_count, outstanding);
		$display("== FAIL ==");
		$finish;
	end

endmodule
